/* sv/dwc_pkg.sv */
package dwc_pkg;

    localparam int SIDE   = 26;
    localparam int KERNEL = 5;
    localparam int DW = 16;
    localparam int ROW_W = 5;
    localparam int COL_W = 5;
    localparam int OVAL_W = 15;
    localparam int FRAC_W = 4;
    localparam int ACC_W = 2 * DW + 6;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd8;
    localparam logic [OVAL_W-1:0] SAT_MAX = 15'h7fff;

    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_PIXEL  = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [5:0]           channel;
        logic [4:0]           tap;
        logic signed [DW-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic [OVAL_W-1:0] out_value;
        logic              last;
        logic              plane_done;
    } t_out_res;

    typedef struct packed {
        logic clear;
        logic step;
    } t_mac_ctl;

endpackage

/* sv/dwc_mac.sv */
module dwc_mac import dwc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mac_ctl             i_ctl,
    input  logic signed [DW-1:0] i_wgt,
    input  logic signed [DW-1:0] i_pix,
    input  logic signed [DW-1:0] i_bias,
    input  logic [FRAC_W-1:0]    i_frac,
    output logic [OVAL_W-1:0]    o_value
);

    logic signed [2*DW-1:0] r_prod;
    logic                   r_pv;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_bias_al;
    logic signed [ACC_W-1:0] w_sh;

    // bias moved onto the product scale
    assign w_bias_al = ACC_W'(i_bias) <<< i_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_wgt * i_pix;
        if (i_ctl.clear) begin
            r_acc <= w_bias_al;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign w_sh = r_acc >>> i_frac;

    always_comb begin
        if (r_acc <= 0) begin
            o_value = '0;
        end else if (w_sh > ACC_W'(SAT_MAX)) begin
            o_value = SAT_MAX;
        end else begin
            o_value = w_sh[OVAL_W-1:0];
        end
    end

endmodule

/* sv/depthwise_conv5x5_bias_relu_core.sv */
// Depthwise KERNEL x KERNEL convolution with zero padding, per-channel bias, ReLU and
// saturation over one SIDE x SIDE plane streamed in raster order. A weight, bias or
// unknown request is taken without stalling the input, as is a pixel that completes no
// window. Each output a pixel completes is then formed by a sweep over the KERNEL*KERNEL
// taps: one multiply-accumulate per cycle through the single multiplier, fed by one read
// per cycle from the weight memory and from the line store. A pixel completing outputs
// holds o_in_stall high until its last output is loaded, also while the output is stalled.
module depthwise_conv5x5_bias_relu_core import dwc_pkg::*; #(
    parameter int CHANNELS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_res          o_out_res,
    input  logic              i_cfg_we,
    input  logic [FRAC_W-1:0] i_cfg_wdata
);

    localparam int TAPS = KERNEL * KERNEL;
    localparam int HALF = KERNEL / 2;
    localparam int RW   = $clog2(SIDE);
    localparam int SR   = RW + 2;
    localparam int SW   = $clog2(KERNEL);
    localparam int TW   = $clog2(TAPS);
    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WAW  = $clog2(CHANNELS * TAPS);
    localparam int LAW  = $clog2(KERNEL * SIDE);
    localparam logic signed [SR-1:0] SIDE_S = SR'(SIDE);
    localparam logic signed [SR-1:0] HALF_S = SR'(HALF);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]        r_state;
    logic [RW-1:0]     r_row, r_col;
    logic [SW-1:0]     r_slot;
    logic [FRAC_W-1:0] r_frac;
    logic [CW-1:0]     r_ch;
    logic [RW-1:0]     r_prow;
    logic [SW-1:0]     r_pslot;
    logic [RW-1:0]     r_oy, r_ox, r_ox_start, r_oy_end, r_ox_end;
    logic              r_pend;
    logic [SW-1:0]     r_kh, r_kw, r_rslot;
    logic [TW-1:0]     r_tap;
    logic              r_drn;
    logic              r_iss, r_inr;
    logic signed [DW-1:0] r_wq, r_lq, r_bq;
    t_out_res          r_out;
    logic              r_out_valid;

    logic signed [DW-1:0] wmem [CHANNELS*TAPS];
    logic signed [DW-1:0] bmem [CHANNELS];
    logic signed [DW-1:0] lmem [KERNEL*SIDE];

    logic [CW-1:0]     w_ch_mod [64];
    logic [CW-1:0]     w_ch;
    logic              w_acc, w_pix;
    logic signed [SR-1:0] w_r, w_c, w_r0, w_r1, w_c0, w_c1, w_rr, w_cc;
    logic              w_has, w_inr;
    logic [SW-1:0]     w_t, w_sslot;
    logic [WAW-1:0]    w_waddr, w_raddr;
    logic [LAW-1:0]    w_lwaddr, w_lraddr;
    logic              w_load, w_olast;
    logic [OVAL_W-1:0] w_value;
    t_mac_ctl          w_ctl;
    logic signed [DW-1:0] w_mpix;

    // channel modulo as a constant table
    for (genvar g = 0; g < 64; g++) begin : g_chmod
        assign w_ch_mod[g] = CW'(g % CHANNELS);
    end

    assign w_ch = w_ch_mod[i_in_req.channel];
    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc = i_in_valid && (r_state == S_IDLE);
    assign w_pix = w_acc && (i_in_req.req_type == REQ_PIXEL);

    // window of outputs completed by this pixel
    assign w_r  = SR'(r_row);
    assign w_c  = SR'(r_col);
    assign w_r0 = w_r - HALF_S;
    assign w_c0 = w_c - HALF_S;
    assign w_r1 = (r_row == RW'(SIDE - 1)) ? w_r : w_r0;
    assign w_c1 = (r_col == RW'(SIDE - 1)) ? w_c : w_c0;
    assign w_has = !w_r1[SR-1] && !w_c1[SR-1];

    // line store slot of the top row of the current window
    assign w_t = SW'(r_prow - r_oy) + SW'(HALF);
    assign w_sslot = (r_pslot >= w_t) ? (r_pslot - w_t) : (r_pslot + SW'(KERNEL) - w_t);

    assign w_rr = SR'(r_oy) - HALF_S + SR'(r_kh);
    assign w_cc = SR'(r_ox) - HALF_S + SR'(r_kw);
    assign w_inr = !w_rr[SR-1] && (w_rr < SIDE_S) && !w_cc[SR-1] && (w_cc < SIDE_S);

    assign w_waddr  = WAW'(w_ch) * WAW'(TAPS) + WAW'(i_in_req.tap);
    assign w_raddr  = WAW'(r_ch) * WAW'(TAPS) + WAW'(r_tap);
    assign w_lwaddr = LAW'(r_slot) * LAW'(SIDE) + LAW'(r_col);
    assign w_lraddr = LAW'(r_rslot) * LAW'(SIDE) + LAW'(w_cc[RW-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_in_req.req_type == REQ_WEIGHT) && (i_in_req.tap < TAPS)) begin
            wmem[w_waddr] <= i_in_req.value;
        end
        r_wq <= wmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_in_req.req_type == REQ_BIAS)) begin
            bmem[w_ch] <= i_in_req.value;
        end
        if (w_pix) begin
            r_bq <= bmem[w_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix) begin
            lmem[w_lwaddr] <= i_in_req.value;
        end
        r_lq <= lmem[w_lraddr];
    end

    assign w_mpix = r_inr ? r_lq : '0;
    assign w_ctl.clear = (r_state == S_START);
    assign w_ctl.step  = r_iss;

    dwc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_wgt   (r_wq),
        .i_pix   (w_mpix),
        .i_bias  (r_bq),
        .i_frac  (r_frac),
        .o_value (w_value)
    );

    assign w_load  = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_olast = (r_oy == r_oy_end) && (r_ox == r_ox_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_slot      <= '0;
            r_frac      <= FRAC_RESET;
            r_iss       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_iss <= (r_state == S_MAC);
            if (i_cfg_we) begin
                r_frac <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pix) begin
                        if (r_col == RW'(SIDE - 1)) begin
                            r_col <= '0;
                            if (r_row == RW'(SIDE - 1)) begin
                                r_row  <= '0;
                                r_slot <= '0;
                            end else begin
                                r_row  <= r_row + 1'b1;
                                r_slot <= (r_slot == SW'(KERNEL - 1)) ? '0 : r_slot + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (w_has) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_tap == TW'(TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_drn) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= w_olast ? S_IDLE : S_START;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers for the window sweep
    always_ff @(posedge i_clk) begin
        r_inr <= w_inr;
        case (r_state)
            S_IDLE: begin
                if (w_pix) begin
                    r_ch       <= w_ch;
                    r_prow     <= r_row;
                    r_pslot    <= r_slot;
                    r_pend     <= (r_row == RW'(SIDE - 1)) && (r_col == RW'(SIDE - 1));
                    r_oy       <= w_r0[SR-1] ? '0 : w_r0[RW-1:0];
                    r_ox       <= w_c0[SR-1] ? '0 : w_c0[RW-1:0];
                    r_ox_start <= w_c0[SR-1] ? '0 : w_c0[RW-1:0];
                    r_oy_end   <= w_r1[RW-1:0];
                    r_ox_end   <= w_c1[RW-1:0];
                end
            end
            S_START: begin
                r_kh    <= '0;
                r_kw    <= '0;
                r_tap   <= '0;
                r_rslot <= w_sslot;
                r_drn   <= 1'b0;
            end
            S_MAC: begin
                r_tap <= r_tap + 1'b1;
                if (r_kw == SW'(KERNEL - 1)) begin
                    r_kw    <= '0;
                    r_kh    <= r_kh + 1'b1;
                    r_rslot <= (r_rslot == SW'(KERNEL - 1)) ? '0 : r_rslot + 1'b1;
                end else begin
                    r_kw <= r_kw + 1'b1;
                end
            end
            S_DRAIN: begin
                r_drn <= 1'b1;
            end
            S_FIN: begin
                if (w_load) begin
                    r_out.out_row    <= ROW_W'(r_oy);
                    r_out.out_col    <= COL_W'(r_ox);
                    r_out.out_value  <= w_value;
                    r_out.last       <= w_olast;
                    r_out.plane_done <= w_olast && r_pend;
                    if (r_ox == r_ox_end) begin
                        r_ox <= r_ox_start;
                        r_oy <= r_oy + 1'b1;
                    end else begin
                        r_ox <= r_ox + 1'b1;
                    end
                end
            end
            default: begin
                r_drn <= 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < RW'(SIDE)) && (r_col < RW'(SIDE)))
        else $error("pixel position out of plane");
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_tap < TW'(TAPS)))
        else $error("tap counter out of range");
    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ((r_oy <= r_oy_end) && (r_ox <= r_ox_end)))
        else $error("output position beyond window");
    a_plane_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_olast && r_pend) |=> ((r_row == '0) && (r_col == '0)))
        else $error("plane end without counter wrap");
`endif

endmodule
